@@ sv/ztfc_pkg.sv @@
// ----------------------------------------------------------------------------
// ztfc_pkg
// shared types and constants of the zero tile flag compressor
// ----------------------------------------------------------------------------
package ztfc_pkg;

  // default tile geometry: a tile is TILE_ROWS x TILE_ROWS/4 words
  localparam int TILE_ROWS_DEF = 16;

  // one bank of the tile store holds the largest tile
  localparam int STORE_DEPTH = 64;
  localparam int POS_W       = $clog2(STORE_DEPTH);
  localparam int RAM_DEPTH   = 2 * STORE_DEPTH;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);

  localparam int WORD_W  = 32;
  localparam int TILES_W = 16;
  localparam int CFG_IDX_W = 2;

  // queue depths (powers of two)
  localparam int DESC_Q_DEPTH = 2;
  localparam int DESC_CNT_W   = $clog2(DESC_Q_DEPTH + 1);
  localparam int OUT_Q_DEPTH  = 4;
  localparam int OUT_CNT_W    = $clog2(OUT_Q_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLAG_WORD       = 2'd0,
    REG_COMPACT_MODE    = 2'd1,
    REG_TILES_IN_MATRIX = 2'd2
  } reg_idx_t;

  // configuration register set
  typedef struct packed {
    logic [WORD_W-1:0]  flag_word;
    logic               compact;
    logic [TILES_W-1:0] tiles;
  } cfg_t;

  // one finished tile, handed from front to back
  typedef struct packed {
    logic              bank;
    logic              all_zero;
    logic              compact;
    logic              last_mat;
    logic [WORD_W-1:0] flag_word;
  } tile_desc_t;

  // one result transaction
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              is_flag;
    logic              tile_end;
    logic              matrix_end;
  } out_item_t;

endpackage

@@ sv/ztfc_ram.sv @@
// ----------------------------------------------------------------------------
// ztfc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ztfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ztfc_fifo.sv @@
// ----------------------------------------------------------------------------
// ztfc_fifo
// small register fifo with occupancy count, power-of-two depth
// ----------------------------------------------------------------------------
module ztfc_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = slot_r[rd_ptr_r];
  assign count    = count_r;

endmodule

@@ sv/ztfc_front.sv @@
// ----------------------------------------------------------------------------
// ztfc_front
// accepts weight words, fills one store bank, classifies the finished tile
// ----------------------------------------------------------------------------
module ztfc_front #(
  parameter int TILE_ROWS = ztfc_pkg::TILE_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ztfc_pkg::WORD_W-1:0]   in_weight_word,
  input  ztfc_pkg::cfg_t                cfg,
  input  logic                          desc_full,
  output logic                          desc_push,
  output ztfc_pkg::tile_desc_t          desc,
  output logic                          ram_we,
  output logic [ztfc_pkg::RAM_AW-1:0]   ram_waddr,
  output logic [ztfc_pkg::WORD_W-1:0]   ram_wdata
);

  localparam int TILE_WORDS = TILE_ROWS * (TILE_ROWS / 4);
  localparam int POS_W      = ztfc_pkg::POS_W;
  localparam int TILES_W    = ztfc_pkg::TILES_W;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               all_zero_r, all_zero_nxt;
  logic               wbank_r, wbank_nxt;
  logic [TILES_W-1:0] tiles_done_r, tiles_done_nxt;

  logic               accept;
  logic               tile_last;
  logic               zero_so_far;
  logic               last_mat;

  // a bank is free whenever the tile queue is not full
  assign in_ready  = !desc_full;
  assign accept    = in_valid && in_ready;
  assign tile_last = (pos_r == POS_W'(TILE_WORDS - 1));

  // classification of the tile being filled
  always_comb begin
    zero_so_far = all_zero_r && (in_weight_word == '0);
    last_mat    = ({1'b0, tiles_done_r} + (TILES_W + 1)'(1)) >= {1'b0, cfg.tiles};
  end

  // next state of the fill side
  always_comb begin
    pos_nxt        = pos_r;
    all_zero_nxt   = all_zero_r;
    wbank_nxt      = wbank_r;
    tiles_done_nxt = tiles_done_r;
    if (accept) begin
      if (tile_last) begin
        pos_nxt        = '0;
        all_zero_nxt   = 1'b1;
        wbank_nxt      = !wbank_r;
        tiles_done_nxt = last_mat ? '0 : tiles_done_r + TILES_W'(1);
      end else begin
        pos_nxt      = pos_r + POS_W'(1);
        all_zero_nxt = zero_so_far;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      all_zero_r   <= 1'b1;
      wbank_r      <= 1'b0;
      tiles_done_r <= '0;
    end else begin
      pos_r        <= pos_nxt;
      all_zero_r   <= all_zero_nxt;
      wbank_r      <= wbank_nxt;
      tiles_done_r <= tiles_done_nxt;
    end
  end

  // store write and tile hand-off
  always_comb begin
    ram_we          = accept;
    ram_waddr       = {wbank_r, pos_r};
    ram_wdata       = in_weight_word;
    desc_push       = accept && tile_last;
    desc.bank       = wbank_r;
    desc.all_zero   = zero_so_far;
    desc.compact    = cfg.compact;
    desc.last_mat   = last_mat;
    desc.flag_word  = cfg.flag_word;
  end

endmodule

@@ sv/ztfc_back.sv @@
// ----------------------------------------------------------------------------
// ztfc_back
// drains finished tiles from the store into the result queue
// ----------------------------------------------------------------------------
module ztfc_back #(
  parameter int TILE_ROWS = ztfc_pkg::TILE_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            desc_valid,
  input  ztfc_pkg::tile_desc_t            desc,
  output logic                            desc_pop,
  output logic [ztfc_pkg::RAM_AW-1:0]     ram_raddr,
  input  logic [ztfc_pkg::WORD_W-1:0]     ram_rdata,
  input  logic [ztfc_pkg::OUT_CNT_W-1:0]  out_count,
  output logic                            out_push,
  output ztfc_pkg::out_item_t             out_item
);

  localparam int TILE_WORDS = TILE_ROWS * (TILE_ROWS / 4);
  localparam int POS_W      = ztfc_pkg::POS_W;
  localparam int WORD_W     = ztfc_pkg::WORD_W;
  localparam int CNT_W      = ztfc_pkg::OUT_CNT_W;

  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic              rd_v_r;
  logic              rd_ovr_r;
  logic [WORD_W-1:0] rd_word_r;
  logic              rd_flag_r, rd_tend_r, rd_mend_r;

  logic              issue;
  logic              shrink;
  logic              word_last;
  logic              sub;
  logic              ovr;
  logic              is_flag;
  logic              tend;
  logic              mend;

  // issue a read only when the result queue has room for it and the one in flight
  always_comb begin
    issue     = desc_valid &&
                (({1'b0, out_count} + (CNT_W + 1)'(rd_v_r)) < (CNT_W + 1)'(ztfc_pkg::OUT_Q_DEPTH));
    shrink    = desc.all_zero && desc.compact;
    word_last = (idx_r == POS_W'(TILE_WORDS - 1));
    sub       = desc.all_zero && (idx_r == '0);
    ovr       = shrink || sub;
    is_flag   = ovr;
    tend      = shrink || word_last;
    mend      = tend && desc.last_mat;
    desc_pop  = issue && tend;
    ram_raddr = {desc.bank, idx_r};
    idx_nxt   = idx_r;
    if (issue) begin
      idx_nxt = tend ? '0 : idx_r + POS_W'(1);
    end
  end

  // word index and read-stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      rd_v_r <= issue;
    end
  end

  // read-stage side data, aligned with the registered ram output
  always_ff @(posedge clk) begin
    rd_ovr_r  <= ovr;
    rd_word_r <= desc.flag_word;
    rd_flag_r <= is_flag;
    rd_tend_r <= tend;
    rd_mend_r <= mend;
  end

  // result assembly
  always_comb begin
    out_push            = rd_v_r;
    out_item.word       = rd_ovr_r ? rd_word_r : ram_rdata;
    out_item.is_flag    = rd_flag_r;
    out_item.tile_end   = rd_tend_r;
    out_item.matrix_end = rd_mend_r;
  end

endmodule

@@ sv/zero_tile_flag_compressor_top.sv @@
// ----------------------------------------------------------------------------
// zero_tile_flag_compressor_top
// zero tile flag compressor: buffers weight tiles and flags all-zero ones
// ----------------------------------------------------------------------------
// Input words are taken one per cycle into a two-bank tile store; while one
// bank is drained the other fills, so input stalls only when both banks hold
// finished tiles. A tile of TILE_ROWS*(TILE_ROWS/4) words drains at one word
// per cycle while the result queue has room, as set by the single read port of
// the store; an all-zero tile in compact mode drains as one flag word. With
// the drain side idle, a tile's first result is offered after the tile queue,
// the read stage and the result queue. The store needs no clearing after
// reset. Configuration is sampled when the last word of a tile is accepted.
module zero_tile_flag_compressor_top #(
  parameter int TILE_ROWS = ztfc_pkg::TILE_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ztfc_pkg::WORD_W-1:0]     in_weight_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ztfc_pkg::WORD_W-1:0]     out_word,
  output logic                            out_is_flag,
  output logic                            out_tile_end,
  output logic                            out_matrix_end,
  input  logic                            cfg_we,
  input  logic [ztfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ztfc_pkg::WORD_W-1:0]     cfg_wdata
);

  localparam int DESC_W = $bits(ztfc_pkg::tile_desc_t);
  localparam int ITEM_W = $bits(ztfc_pkg::out_item_t);

  ztfc_pkg::cfg_t       cfg_r, cfg_nxt;
  ztfc_pkg::tile_desc_t push_desc, head_desc;
  ztfc_pkg::out_item_t  push_item, head_item;

  logic                                desc_push, desc_pop;
  logic [ztfc_pkg::DESC_CNT_W-1:0]     desc_count;
  logic                                out_push, out_pop;
  logic [ztfc_pkg::OUT_CNT_W-1:0]      out_count;
  logic                                ram_we;
  logic [ztfc_pkg::RAM_AW-1:0]         ram_waddr, ram_raddr;
  logic [ztfc_pkg::WORD_W-1:0]         ram_wdata, ram_rdata;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ztfc_pkg::REG_FLAG_WORD:       cfg_nxt.flag_word = cfg_wdata;
        ztfc_pkg::REG_COMPACT_MODE:    cfg_nxt.compact   = cfg_wdata[0];
        ztfc_pkg::REG_TILES_IN_MATRIX: cfg_nxt.tiles     = cfg_wdata[ztfc_pkg::TILES_W-1:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_word <= '0;
      cfg_r.compact   <= 1'b1;
      cfg_r.tiles     <= ztfc_pkg::TILES_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // fill side
  ztfc_front #(.TILE_ROWS(TILE_ROWS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_weight_word (in_weight_word),
    .cfg            (cfg_r),
    .desc_full      (desc_count == ztfc_pkg::DESC_CNT_W'(ztfc_pkg::DESC_Q_DEPTH)),
    .desc_push      (desc_push),
    .desc           (push_desc),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  // two-bank tile store
  ztfc_ram #(.WIDTH(ztfc_pkg::WORD_W), .DEPTH(ztfc_pkg::RAM_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // finished tile queue, one entry per bank
  ztfc_fifo #(.WIDTH(DESC_W), .DEPTH(ztfc_pkg::DESC_Q_DEPTH)) u_desc_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_data (push_desc),
    .pop       (desc_pop),
    .pop_data  (head_desc),
    .count     (desc_count)
  );

  // drain side
  ztfc_back #(.TILE_ROWS(TILE_ROWS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_count != '0),
    .desc       (head_desc),
    .desc_pop   (desc_pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_count  (out_count),
    .out_push   (out_push),
    .out_item   (push_item)
  );

  // result queue in front of the output port
  ztfc_fifo #(.WIDTH(ITEM_W), .DEPTH(ztfc_pkg::OUT_Q_DEPTH)) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (out_push),
    .push_data (push_item),
    .pop       (out_pop),
    .pop_data  (head_item),
    .count     (out_count)
  );

  // output port
  assign out_valid      = (out_count != '0);
  assign out_pop        = out_valid && out_ready;
  assign out_word       = head_item.word;
  assign out_is_flag    = head_item.is_flag;
  assign out_tile_end   = head_item.tile_end;
  assign out_matrix_end = head_item.matrix_end;

endmodule

@@ sv/ztfc_checker.sv @@
// ----------------------------------------------------------------------------
// ztfc_checker
// port-level checks of the zero tile flag compressor
// ----------------------------------------------------------------------------
module ztfc_port_checks (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [ztfc_pkg::WORD_W-1:0]     in_weight_word,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ztfc_pkg::WORD_W-1:0]     out_word,
  input logic                            out_is_flag,
  input logic                            out_tile_end,
  input logic                            out_matrix_end
);

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a matrix only ends at a tile boundary
  a_mend_tend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matrix_end |-> out_tile_end)
    else $error("matrix end without tile end");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) &&
    $stable(out_is_flag) && $stable(out_tile_end) && $stable(out_matrix_end))
    else $error("stalled result changed");

  // a stalled weight transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_weight_word))
    else $error("stalled weight changed");

endmodule

bind zero_tile_flag_compressor_top ztfc_port_checks u_ztfc_checker (.*);
